@@ hw/rtl/lgsc_pkg.sv @@
// Shared constants and types for the custom glyph slot cache.
// No dependencies; used by lgsc_slot_table and the top level.
`default_nettype none

package lgsc_pkg;

    // Number of custom glyph slots on the display controller (1 to 8)
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int CODE_W     = 8;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 2;
    localparam int FONT_COLS  = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int GLYPH_W    = FONT_COLS * GLYPH_ROWS;

    // First custom glyph code
    localparam logic [CODE_W-1:0] CUSTOM_BASE = 8'h80;

    // Reset value of the glyph count register
    localparam logic [CODE_W-1:0] GLYPH_COUNT_RST = 8'd64;

    typedef enum logic {
        WK_DIRECT = 1'b0,
        WK_CUSTOM = 1'b1
    } t_write_kind;

    // Lookup request towards the slot table
    typedef struct packed {
        logic              commit;  // item leaves the input register as a custom write
        logic [CODE_W-1:0] code;
    } t_slot_req;

    // Lookup answer from the slot table
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_slot_rsp;

endpackage

`default_nettype wire

@@ hw/rtl/lgsc_slot_table.sv @@
// Slot code table with lowest-match lookup and round-robin replacement.
// Depends on lgsc_pkg.
`default_nettype none

module lgsc_slot_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lgsc_pkg::t_slot_req i_req,
    output lgsc_pkg::t_slot_rsp     o_rsp
);

    logic [lgsc_pkg::CODE_W-1:0] r_slot_codes [lgsc_pkg::SLOT_COUNT];
    logic [lgsc_pkg::SLOT_W-1:0] r_next_slot;
    logic [lgsc_pkg::SLOT_W-1:0] n_next_slot;
    logic [lgsc_pkg::SLOT_COUNT-1:0] match;
    logic [lgsc_pkg::SLOT_W-1:0] hit_slot;

    always_comb begin
        for (int i = 0; i < lgsc_pkg::SLOT_COUNT; i++) begin
            match[i] = (r_slot_codes[i] == i_req.code);
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit_slot = '0;
        for (int i = lgsc_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_slot = lgsc_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (r_next_slot == lgsc_pkg::SLOT_W'(lgsc_pkg::SLOT_COUNT - 1)) begin
            n_next_slot = '0;
        end else begin
            n_next_slot = r_next_slot + 1'b1;
        end
    end

    assign o_rsp.hit  = |match;
    assign o_rsp.slot = (|match) ? hit_slot : r_next_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lgsc_pkg::SLOT_COUNT; i++) begin
                r_slot_codes[i] <= '0;
            end
            r_next_slot <= '0;
        end else if (i_req.commit && !(|match)) begin
            r_slot_codes[r_next_slot] <= i_req.code;
            r_next_slot               <= n_next_slot;
        end
    end

    // a committed code is held in the slot that was reported for it
    a_commit_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.commit |=> r_slot_codes[$past(o_rsp.slot)] == $past(i_req.code))
        else $error("committed code not found in its slot");

    // pointer moves only on a miss
    a_ptr_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.commit && !o_rsp.hit) |=> r_next_slot == $past(r_next_slot))
        else $error("replacement pointer moved without a miss");

    // a hit never points at the replacement pointer unless that slot really matches
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.hit |-> r_slot_codes[o_rsp.slot] == i_req.code)
        else $error("hit reported on a slot that does not match");

endmodule

`default_nettype wire

@@ hw/rtl/lcd_custom_glyph_slot_cache_core.sv @@
// Top level of the custom glyph slot cache: input register, classify and
// transpose logic, result register. Depends on lgsc_pkg and lgsc_slot_table.
`default_nettype none

// One character per transfer in, one display write per transfer out. Codes
// from 0x80 up to (not including) 0x80 + glyph count are custom glyphs: they
// are looked up in an 8-entry slot table (lowest matching slot wins, a miss
// replaces the slot under a round-robin pointer) and come out as a custom
// write carrying the slot number and the glyph bitmap transposed from the
// five font columns (row r bit k = column k bit 7-r). Every other code is a
// direct write with zero glyph rows. Throughput is one character per clock
// while the sink does not stall. The character is captured in the input
// register and then moves into the result register; the slot lookup and
// table update happen on that move. The result register lets a new
// character in while a finished write is still held by a stalled sink.
// The glyph count register is written through i_cfg_we/i_cfg_wdata and
// resets to 64; write it only while no character is in flight. The slot
// table is cleared by reset, so there is no start-up delay.
module lcd_custom_glyph_slot_cache_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [lgsc_pkg::CODE_W-1:0]    i_cfg_wdata,
    // character input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [lgsc_pkg::CODE_W-1:0]    i_char_code,
    input  wire logic [lgsc_pkg::COL_W-1:0]     i_cursor_col,
    input  wire logic [lgsc_pkg::ROW_W-1:0]     i_cursor_row,
    input  wire logic [lgsc_pkg::GLYPH_W-1:0]   i_glyph_columns,
    // display write output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_write_kind,
    output logic [lgsc_pkg::CODE_W-1:0]         o_display_code,
    output logic [lgsc_pkg::COL_W-1:0]          o_out_col,
    output logic [lgsc_pkg::ROW_W-1:0]          o_out_row,
    output logic [lgsc_pkg::GLYPH_W-1:0]        o_glyph_rows
);

    // glyph count register
    logic [lgsc_pkg::CODE_W-1:0]  r_glyph_count;

    // input register
    logic                         r_in_valid;
    logic [lgsc_pkg::CODE_W-1:0]  r_in_code;
    logic [lgsc_pkg::COL_W-1:0]   r_in_col;
    logic [lgsc_pkg::ROW_W-1:0]   r_in_row;
    logic [lgsc_pkg::GLYPH_W-1:0] r_in_cols;

    // result register
    logic                         r_out_valid;
    lgsc_pkg::t_write_kind        r_out_kind;
    logic [lgsc_pkg::CODE_W-1:0]  r_out_code;
    logic [lgsc_pkg::COL_W-1:0]   r_out_col;
    logic [lgsc_pkg::ROW_W-1:0]   r_out_row;
    logic [lgsc_pkg::GLYPH_W-1:0] r_out_rows;

    logic                         advance;     // input register moves into result register
    logic                         in_xfer;
    logic                         is_custom;
    logic [lgsc_pkg::CODE_W:0]    code_limit;  // 9 bits: no wrap on large counts
    lgsc_pkg::t_slot_req          slot_req;
    lgsc_pkg::t_slot_rsp          slot_rsp;
    lgsc_pkg::t_write_kind        n_out_kind;
    logic [lgsc_pkg::CODE_W-1:0]  n_out_code;
    logic [lgsc_pkg::GLYPH_W-1:0] glyph_t;
    logic [lgsc_pkg::GLYPH_W-1:0] n_out_rows;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // custom range check, 0x80 <= code < 0x80 + count
    assign code_limit = {1'b0, lgsc_pkg::CUSTOM_BASE} + {1'b0, r_glyph_count};
    assign is_custom  = (r_in_code >= lgsc_pkg::CUSTOM_BASE)
                      && ({1'b0, r_in_code} < code_limit);

    assign slot_req.commit = advance && is_custom;
    assign slot_req.code   = r_in_code;

    lgsc_slot_table u_slot_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (slot_req),
        .o_rsp   (slot_rsp)
    );

    // column-major font bytes to row-major glyph: pure wiring
    always_comb begin
        for (int r = 0; r < lgsc_pkg::GLYPH_ROWS; r++) begin
            for (int k = 0; k < lgsc_pkg::FONT_COLS; k++) begin
                glyph_t[lgsc_pkg::FONT_COLS*r + k] = r_in_cols[8*k + (7 - r)];
            end
        end
    end

    always_comb begin
        if (is_custom) begin
            n_out_kind = lgsc_pkg::WK_CUSTOM;
            n_out_code = {{(lgsc_pkg::CODE_W - lgsc_pkg::SLOT_W){1'b0}}, slot_rsp.slot};
            n_out_rows = glyph_t;
        end else begin
            n_out_kind = lgsc_pkg::WK_DIRECT;
            n_out_code = r_in_code;
            n_out_rows = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_count <= lgsc_pkg::GLYPH_COUNT_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_glyph_count <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_code <= i_char_code;
            r_in_col  <= i_cursor_col;
            r_in_row  <= i_cursor_row;
            r_in_cols <= i_glyph_columns;
        end
        if (advance) begin
            r_out_kind <= n_out_kind;
            r_out_code <= n_out_code;
            r_out_col  <= r_in_col;
            r_out_row  <= r_in_row;
            r_out_rows <= n_out_rows;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_kind   = r_out_kind;
    assign o_display_code = r_out_code;
    assign o_out_col      = r_out_col;
    assign o_out_row      = r_out_row;
    assign o_glyph_rows   = r_out_rows;

    // the input side only stalls while it holds a character
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // direct writes carry no bitmap
    a_direct_no_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == lgsc_pkg::WK_DIRECT) |-> r_out_rows == '0)
        else $error("direct write with non-zero glyph rows");

    // custom writes always name an existing slot
    a_custom_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == lgsc_pkg::WK_CUSTOM)
            |-> r_out_code < lgsc_pkg::CODE_W'(lgsc_pkg::SLOT_COUNT))
        else $error("custom write with slot out of range");

endmodule

`default_nettype wire
